// ===== design/bpc_pkg.sv =====
// bpc_pkg: shared types, constants and helpers for the button press classifier.
// No dependencies; compiled first.
package bpc_pkg;

  // Width of the wrapping millisecond time base.
  localparam int TIME_BITS  = 32;
  localparam int NOW_W      = 32;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  typedef logic [TIME_BITS-1:0]  time_t;
  typedef logic [CFG_DATA_W-1:0] ms_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IDLE_HIGH     = 3'd0,
    REG_DEBOUNCE      = 3'd1,
    REG_LONG_PRESS    = 3'd2,
    REG_LONG_REPEAT   = 3'd3,
    REG_TRIPLE_WINDOW = 3'd4
  } cfg_reg_t;

  localparam logic RST_IDLE_HIGH     = 1'b1;
  localparam ms_t  RST_DEBOUNCE      = 16'd30;
  localparam ms_t  RST_LONG_PRESS    = 16'd500;
  localparam ms_t  RST_LONG_REPEAT   = 16'd500;
  localparam ms_t  RST_TRIPLE_WINDOW = 16'd500;

  localparam logic [1:0] TRIPLE_COUNT = 2'd3;

  typedef struct packed {
    logic idle_high;
    ms_t  debounce_ms;
    ms_t  long_press_ms;
    ms_t  long_repeat_ms;
    ms_t  triple_window_ms;
  } cfg_t;

  typedef struct packed {
    logic             level;
    logic [NOW_W-1:0] now_ms;
  } smp_t;

  typedef struct packed {
    logic short_press;
    logic long_press;
    logic triple_press;
  } res_t;

  // Wrapping difference now - then.
  function automatic time_t elapsed(input time_t now, input time_t then_t);
    elapsed = now - then_t;
  endfunction

  // Wrapped elapsed time strictly beyond a 16-bit limit.
  function automatic logic past_limit(input time_t now, input time_t then_t, input ms_t lim);
    past_limit = elapsed(now, then_t) > TIME_BITS'(lim);
  endfunction

endpackage

// ===== design/bpc_if.sv =====
// bpc_if: valid/ready channel interfaces for the button press classifier.
// Depends on bpc_pkg.
interface bpc_in_if;
  import bpc_pkg::*;
  logic             valid;
  logic             ready;
  logic             level;
  logic [NOW_W-1:0] now_ms;

  modport source (output valid, output level, output now_ms, input ready);
  modport sink   (input valid, input level, input now_ms, output ready);
endinterface

interface bpc_out_if;
  logic valid;
  logic ready;
  logic short_press;
  logic long_press;
  logic triple_press;

  modport source (output valid, output short_press, output long_press,
                  output triple_press, input ready);
  modport sink   (input valid, input short_press, input long_press,
                  input triple_press, output ready);
endinterface

// ===== design/bpc_core.sv =====
// bpc_core: press state and combinational classification of one sample.
// Depends on bpc_pkg.
module bpc_core (
  input  logic          clk,
  input  logic          rst_n,
  input  bpc_pkg::cfg_t cfg,
  input  logic          acc,
  input  bpc_pkg::smp_t smp,
  output bpc_pkg::res_t res
);
  import bpc_pkg::*;

  logic       prev_level_r, held_down_r, held_long_r;
  time_t      press_time_r, long_time_r, short_time_r;
  logic [1:0] short_count_r;

  logic       held_down_nxt, held_long_nxt;
  time_t      press_time_nxt, long_time_nxt, short_time_nxt;
  logic [1:0] short_count_nxt;

  time_t now;
  logic  cur_p, prev_p;

  always_comb begin
    now    = TIME_BITS'(smp.now_ms);
    cur_p  = smp.level != cfg.idle_high;
    prev_p = prev_level_r != cfg.idle_high;

    held_down_nxt   = held_down_r;
    held_long_nxt   = held_long_r;
    press_time_nxt  = press_time_r;
    long_time_nxt   = long_time_r;
    short_time_nxt  = short_time_r;
    short_count_nxt = short_count_r;
    res             = '0;

    // release edge goes first, so a release never sees a long event
    if (!cur_p && prev_p) begin
      if (held_down_r && !held_long_r) begin
        res.short_press = 1'b1;
        short_time_nxt  = now;
        short_count_nxt = short_count_r + 2'd1;
      end
      held_down_nxt = 1'b0;
      held_long_nxt = 1'b0;
    end

    if (cur_p && !prev_p)
      press_time_nxt = now;

    if (cur_p && prev_p && past_limit(now, press_time_nxt, cfg.debounce_ms))
      held_down_nxt = 1'b1;

    if (held_down_nxt && past_limit(now, press_time_nxt, cfg.long_press_ms) &&
        past_limit(now, long_time_r, cfg.long_repeat_ms)) begin
      long_time_nxt  = now;
      held_long_nxt  = 1'b1;
      res.long_press = 1'b1;
    end

    if (short_count_nxt == TRIPLE_COUNT) begin
      res.triple_press = 1'b1;
      short_count_nxt  = 2'd0;
    end
    if (past_limit(now, short_time_nxt, cfg.triple_window_ms))
      short_count_nxt = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r  <= 1'b1;
      held_down_r   <= 1'b0;
      held_long_r   <= 1'b0;
      press_time_r  <= '0;
      long_time_r   <= '0;
      short_time_r  <= '0;
      short_count_r <= 2'd0;
    end else if (acc) begin
      prev_level_r  <= smp.level;
      held_down_r   <= held_down_nxt;
      held_long_r   <= held_long_nxt;
      press_time_r  <= press_time_nxt;
      long_time_r   <= long_time_nxt;
      short_time_r  <= short_time_nxt;
      short_count_r <= short_count_nxt;
    end
  end

endmodule

// ===== design/button_press_classifier.sv =====
// button_press_classifier: top level; config registers, core and output buffer.
// Depends on bpc_pkg, bpc_if and bpc_core.
//
//   channel  | dir | payload                                  | handshake
//   ---------+-----+------------------------------------------+-------------
//   in_ch    | in  | level, now_ms[31:0]                      | valid/ready
//   out_ch   | out | short_press, long_press, triple_press    | valid/ready
//   cfg_*    | in  | cfg_index[2:0], cfg_data[15:0]           | cfg_we only
//
// One sample per clock while in_ch.ready is high: the core classifies a sample in
// the cycle it is accepted and updates its press state at that edge; the result is
// registered in the output register, or in skid if out_ch stalls. Every transaction
// gives one result. A two-entry output buffer (output register plus skid) keeps
// in_ch.ready high while one result waits; ready drops only when both are full.
// rst_n is synchronous, active low; it restores register defaults and press state.
module button_press_classifier (
  input  logic                                clk,
  input  logic                                rst_n,
  bpc_in_if.sink                              in_ch,
  bpc_out_if.source                           out_ch,
  input  logic                                cfg_we,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import bpc_pkg::*;

  cfg_t cfg_r;
  smp_t smp;
  res_t res_new, out_data_r, skid_data_r;
  logic out_valid_r, skid_valid_r;
  logic acc, pop;

  // configuration registers; writes outside the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.idle_high        <= RST_IDLE_HIGH;
      cfg_r.debounce_ms      <= RST_DEBOUNCE;
      cfg_r.long_press_ms    <= RST_LONG_PRESS;
      cfg_r.long_repeat_ms   <= RST_LONG_REPEAT;
      cfg_r.triple_window_ms <= RST_TRIPLE_WINDOW;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IDLE_HIGH:     cfg_r.idle_high        <= cfg_data[0];
        REG_DEBOUNCE:      cfg_r.debounce_ms      <= cfg_data;
        REG_LONG_PRESS:    cfg_r.long_press_ms    <= cfg_data;
        REG_LONG_REPEAT:   cfg_r.long_repeat_ms   <= cfg_data;
        REG_TRIPLE_WINDOW: cfg_r.triple_window_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = !skid_valid_r;
  assign acc         = in_ch.valid && in_ch.ready;
  assign pop         = out_valid_r && out_ch.ready;
  assign smp.level   = in_ch.level;
  assign smp.now_ms  = in_ch.now_ms;

  bpc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .acc   (acc),
    .smp   (smp),
    .res   (res_new)
  );

  // output register with skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= acc;
      end
    end else if (acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      out_data_r <= skid_valid_r ? skid_data_r : res_new;
    end else if (acc) begin
      skid_data_r <= res_new;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.short_press  = out_data_r.short_press;
  assign out_ch.long_press   = out_data_r.long_press;
  assign out_ch.triple_press = out_data_r.triple_press;

endmodule

// ===== design/bpc_checker.sv =====
// bpc_props: port-level assertions for button_press_classifier, with its bind.
// Depends on button_press_classifier and bpc_if.
module bpc_props (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic short_press,
  input logic long_press,
  input logic triple_press
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // input only backs up once a result is waiting
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  // a release cannot also fire a long event
  a_short_long: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(short_press && long_press))
    else $error("short and long press on one sample");

  // a triple is always completed by a short press
  a_triple_short: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && triple_press |-> short_press)
    else $error("triple press without short press");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind button_press_classifier bpc_props u_bpc_props (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .short_press  (out_ch.short_press),
  .long_press   (out_ch.long_press),
  .triple_press (out_ch.triple_press)
);
